// ===== hw/rtl/kcl_pkg.sv =====
// kcl_pkg: shared types, register indexes, event codes and reset values
// for the keypad code lock; no dependencies
`timescale 1ns / 1ps

package kcl_pkg;

    localparam int CODE_LENGTH_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_KEY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_KEY    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CODE    = 3'd6;

    // register reset values
    localparam logic [31:0] RST_STORED_CODE   = 32'd0;
    localparam logic [15:0] RST_SESSION_LIMIT = 16'd30000;
    localparam logic [23:0] RST_LOCKOUT_TICKS = 24'd120000;
    localparam logic [3:0]  RST_MAX_FAILS     = 4'd3;
    localparam logic [7:0]  RST_ENTER_KEY     = 8'd11;
    localparam logic [7:0]  RST_CHANGE_KEY    = 8'd12;
    localparam logic [7:0]  RST_BLANK_CODE    = 8'd0;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_DIGIT   = 4'd1,
        EV_UNLOCK  = 4'd2,
        EV_WRONG   = 4'd3,
        EV_LOCK    = 4'd4,
        EV_TIMEOUT = 4'd5,
        EV_CHANGE  = 4'd6,
        EV_FREE    = 4'd7,
        EV_IGNORED = 4'd8
    } ev_t;

    typedef struct packed {
        logic [31:0] stored_code;
        logic [15:0] session_limit;
        logic [23:0] lockout_ticks;
        logic [3:0]  max_fails;
        logic [7:0]  enter_key;
        logic [7:0]  change_key;
        logic [7:0]  blank_code;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] key_code;
    } item_t;

    typedef struct packed {
        ev_t         ev;
        logic [31:0] display_chars;
        logic [3:0]  fails_so_far;
    } res_t;

endpackage

// ===== hw/rtl/kcl_core.sv =====
// kcl_core: lock state registers and the one-step update for a key or tick
// depends on kcl_pkg
`timescale 1ns / 1ps

module kcl_core
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  step,
    input  item_t item,
    output res_t  res
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);

    logic [7:0]       ebuf_reg [CODE_LENGTH];
    logic [7:0]       ebuf_next [CODE_LENGTH];
    logic [31:0]      disp_reg, disp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      sess_reg, sess_next;
    logic [3:0]       fail_reg, fail_next;
    logic [23:0]      lock_reg, lock_next;
    logic             barred_reg, barred_next;

    logic             match;
    logic [15:0]      sess_inc;
    logic [3:0]       fail_inc;
    logic             do_clear;
    ev_t              ev;
    logic [7:0]       shown [4];

    always_comb
    begin
        match = 1'b1;
        for (int p = 0; p < CODE_LENGTH; p++)
        begin
            if (p < CODE_LENGTH - 4)
            begin
                if (ebuf_reg[p] != cfg.blank_code)
                    match = 1'b0;
            end
            else
            begin
                // byte select stays in range even for the older positions
                if (ebuf_reg[p] != cfg.stored_code[8*((CODE_LENGTH-1-p) % 4) +: 8])
                    match = 1'b0;
            end
        end
    end

    assign sess_inc = (sess_reg == 16'hFFFF) ? sess_reg : sess_reg + 16'd1;
    assign fail_inc = (fail_reg == 4'hF) ? fail_reg : fail_reg + 4'd1;

    always_comb
    begin
        for (int p = 0; p < CODE_LENGTH; p++)
            ebuf_next[p] = ebuf_reg[p];
        disp_next   = disp_reg;
        count_next  = count_reg;
        sess_next   = sess_reg;
        fail_next   = fail_reg;
        lock_next   = lock_reg;
        barred_next = barred_reg;
        do_clear    = 1'b0;
        ev          = EV_NONE;

        if (barred_reg)
        begin
            if (!item.func)
            begin
                if (lock_reg <= 24'd1)
                begin
                    lock_next   = '0;
                    barred_next = 1'b0;
                    fail_next   = '0;
                    do_clear    = 1'b1;
                    ev          = EV_FREE;
                end
                else
                begin
                    lock_next = lock_reg - 24'd1;
                end
            end
            else
            begin
                ev = EV_IGNORED;
            end
        end
        else if (!item.func)
        begin
            sess_next = sess_inc;
            if (sess_inc >= cfg.session_limit)
            begin
                do_clear  = 1'b1;
                fail_next = '0;
                ev        = EV_TIMEOUT;
            end
        end
        else if (item.key_code == cfg.enter_key)
        begin
            do_clear = 1'b1;
            if (match)
            begin
                fail_next = '0;
                ev        = EV_UNLOCK;
            end
            else
            begin
                fail_next = fail_inc;
                if (fail_inc >= cfg.max_fails)
                begin
                    barred_next = 1'b1;
                    lock_next   = cfg.lockout_ticks;
                    ev          = EV_LOCK;
                end
                else
                begin
                    ev = EV_WRONG;
                end
            end
        end
        else if (item.key_code == cfg.change_key)
        begin
            do_clear = 1'b1;
            ev       = EV_CHANGE;
        end
        else
        begin
            // fill from the oldest position, then slide once full
            if (count_reg < CNT_W'(CODE_LENGTH))
            begin
                for (int p = 0; p < CODE_LENGTH; p++)
                    if (count_reg == CNT_W'(p))
                        ebuf_next[p] = item.key_code;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                for (int p = 0; p < CODE_LENGTH - 1; p++)
                    ebuf_next[p] = ebuf_reg[p+1];
                ebuf_next[CODE_LENGTH-1] = item.key_code;
            end
            disp_next = {disp_reg[23:0], item.key_code};
            ev        = EV_DIGIT;
        end

        if (do_clear)
        begin
            for (int p = 0; p < CODE_LENGTH; p++)
                ebuf_next[p] = cfg.blank_code;
            count_next = '0;
            sess_next  = '0;
        end
    end

    // positions not yet entered show the blank code in force now
    always_comb
    begin
        for (int j = 0; j < 4; j++)
            shown[j] = (count_next > CNT_W'(j)) ? disp_next[8*j +: 8] : cfg.blank_code;
    end

    assign res.ev            = ev;
    assign res.display_chars = {shown[3], shown[2], shown[1], shown[0]};
    assign res.fails_so_far  = fail_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < CODE_LENGTH; p++)
                ebuf_reg[p] <= RST_BLANK_CODE;
            disp_reg   <= '0;
            count_reg  <= '0;
            sess_reg   <= '0;
            fail_reg   <= '0;
            lock_reg   <= '0;
            barred_reg <= 1'b0;
        end
        else if (step)
        begin
            for (int p = 0; p < CODE_LENGTH; p++)
                ebuf_reg[p] <= ebuf_next[p];
            disp_reg   <= disp_next;
            count_reg  <= count_next;
            sess_reg   <= sess_next;
            fail_reg   <= fail_next;
            lock_reg   <= lock_next;
            barred_reg <= barred_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CODE_LENGTH))
        else $error("entry count beyond code length");

    a_bar_on_lock: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(barred_reg) |-> $past(step && ev == EV_LOCK))
        else $error("lockout started without a lockout event");

    a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(barred_reg) |-> (fail_reg == 4'd0 && count_reg == '0))
        else $error("lockout ended without clearing fails and entry");

    a_barred_key_inert: assert property (@(posedge clk) disable iff (!rst_n)
        step && barred_reg && item.func |=>
            $stable(count_reg) && $stable(fail_reg) && $stable(lock_reg) && barred_reg)
        else $error("key during lockout changed state");
`endif

endmodule

// ===== hw/rtl/keypad_code_lock.sv =====
// keypad_code_lock: top level with stream handshakes and configuration registers
// depends on kcl_pkg and kcl_core
`timescale 1ns / 1ps

// Keypad code lock.
// Input stream: one beat per key press or time tick; s_axis_tuser is 1 for a key
// and 0 for a tick, s_axis_tdata carries the key code. Each input beat gives
// exactly one output beat: m_axis_tuser is the event code, m_axis_tdata holds
// the four shown keys (newest in the low byte) and the fail count.
// Configuration: cfg_we writes register cfg_index with cfg_data at the clock
// edge; write only while no beat is in flight.
// Path: an accepted beat is held in the input register, and the core's update
// of it is registered into the output register once that register is free.
// Throughput: one beat per cycle while the receiver keeps up; the single-step
// update between the input register and the output register sets that rate.
// When the receiver stalls, the output register holds its beat and the input
// register holds one more; s_axis_tready drops only when both are full.
// Reset clears the lock state, the entry buffer, the fail count and loads the
// default register values; both stream sides come up empty.

module keypad_code_lock
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // key_code
    input  logic                  s_axis_tuser,   // func

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // display_chars, fails_so_far, zero pad
    output logic [3:0]            m_axis_tuser,   // event_res

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  in_valid_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    res_t  out_res_reg;
    res_t  res;
    logic  out_free;
    logic  advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stored_code   <= RST_STORED_CODE;
            cfg_reg.session_limit <= RST_SESSION_LIMIT;
            cfg_reg.lockout_ticks <= RST_LOCKOUT_TICKS;
            cfg_reg.max_fails     <= RST_MAX_FAILS;
            cfg_reg.enter_key     <= RST_ENTER_KEY;
            cfg_reg.change_key    <= RST_CHANGE_KEY;
            cfg_reg.blank_code    <= RST_BLANK_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STORED_CODE:   cfg_reg.stored_code   <= cfg_data;
                CFG_SESSION_LIMIT: cfg_reg.session_limit <= cfg_data[15:0];
                CFG_LOCKOUT_TICKS: cfg_reg.lockout_ticks <= cfg_data[23:0];
                CFG_MAX_FAILS:     cfg_reg.max_fails     <= cfg_data[3:0];
                CFG_ENTER_KEY:     cfg_reg.enter_key     <= cfg_data[7:0];
                CFG_CHANGE_KEY:    cfg_reg.change_key    <= cfg_data[7:0];
                CFG_BLANK_CODE:    cfg_reg.blank_code    <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_free)
                out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.func     <= s_axis_tuser;
            in_item_reg.key_code <= s_axis_tdata;
        end
        if (advance)
            out_res_reg <= res;
    end

    kcl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (advance),
        .item  (in_item_reg),
        .res   (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.fails_so_far, out_res_reg.display_chars};
    assign m_axis_tuser  = out_res_reg.ev;

endmodule
